// ===== hw/rtl/bresenham_line_pixel_generator_core_assert.svh =====
// assertion helpers for the line generator rtl
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BLPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BLPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/blpg_pkg.sv =====
`default_nettype none

package blpg_pkg;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  x_end;
    logic [7:0]  y_end;
    logic [11:0] line_color;
  } blpg_in_t;

  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [11:0] pixel_color;
    logic        last;
  } blpg_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/blpg_walker.sv =====
`default_nettype none

module blpg_walker
  import blpg_pkg::*;
#(
  parameter int unsigned SCREEN_MAX = 131
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire blpg_in_t  item_i,
  input  wire logic      rotate_i,
  output logic           has_result_o,
  output blpg_out_t      pixel_o
);

  localparam logic [7:0] ScreenMaxLo = 8'(SCREEN_MAX);

  function automatic logic [7:0] step_coord(input logic [7:0] v, input logic negative);
    step_coord = negative ? v - 8'd1 : v + 8'd1;
  endfunction

  logic [7:0]        walk_x_q, walk_y_q, target_x_q, target_y_q;
  logic [7:0]        walk_x_d, walk_y_d, target_x_d, target_y_d;
  logic [8:0]        twice_dx_q, twice_dy_q, twice_dx_d, twice_dy_d;
  logic              neg_x_q, neg_y_q, neg_x_d, neg_y_d;
  logic signed [9:0] err_q, err_d;
  logic              x_major_q, x_major_d;
  logic [11:0]       color_q, color_d;
  logic              active_q;

  logic              start;
  logic [7:0]        x0, y0, x1, y1;
  logic [8:0]        dx9, dy9;
  logic [7:0]        adx, ady;
  logic              err_pos;
  logic [10:0]       err_ext, err_sub, err_step;
  logic              done;

  assign start = (item_i.mode == MODE_START);

  always_comb begin
    // endpoints, axes swapped under rotation
    if (rotate_i) begin
      x0 = item_i.y_start;
      y0 = item_i.x_start;
      x1 = item_i.y_end;
      y1 = item_i.x_end;
    end else begin
      x0 = item_i.x_start;
      y0 = item_i.y_start;
      x1 = item_i.x_end;
      y1 = item_i.y_end;
    end
    dx9 = {1'b0, x1} - {1'b0, x0};
    dy9 = {1'b0, y1} - {1'b0, y0};
    adx = dx9[8] ? 8'(-dx9) : dx9[7:0];
    ady = dy9[8] ? 8'(-dy9) : dy9[7:0];

    // one error update on the stored line
    err_pos = !err_q[9];
    err_ext = {err_q[9], err_q};

    walk_x_d   = walk_x_q;
    walk_y_d   = walk_y_q;
    target_x_d = target_x_q;
    target_y_d = target_y_q;
    twice_dx_d = twice_dx_q;
    twice_dy_d = twice_dy_q;
    neg_x_d    = neg_x_q;
    neg_y_d    = neg_y_q;
    x_major_d  = x_major_q;
    color_d    = color_q;
    err_sub    = '0;
    err_step   = '0;

    if (start) begin
      walk_x_d   = x0;
      walk_y_d   = y0;
      target_x_d = x1;
      target_y_d = y1;
      neg_x_d    = dx9[8];
      neg_y_d    = dy9[8];
      twice_dx_d = {adx, 1'b0};
      twice_dy_d = {ady, 1'b0};
      x_major_d  = {adx, 1'b0} > {ady, 1'b0};
      color_d    = item_i.line_color;
      if (x_major_d) begin
        err_d = {1'b0, ady, 1'b0} - {2'b0, adx};
      end else begin
        err_d = {1'b0, adx, 1'b0} - {2'b0, ady};
      end
    end else begin
      if (x_major_q) begin
        if (err_pos) begin
          walk_y_d = step_coord(walk_y_q, neg_y_q);
          err_sub  = {2'b0, twice_dx_q};
        end
        walk_x_d = step_coord(walk_x_q, neg_x_q);
        err_step = err_ext - err_sub + {2'b0, twice_dy_q};
      end else begin
        if (err_pos) begin
          walk_x_d = step_coord(walk_x_q, neg_x_q);
          err_sub  = {2'b0, twice_dy_q};
        end
        walk_y_d = step_coord(walk_y_q, neg_y_q);
        err_step = err_ext - err_sub + {2'b0, twice_dx_q};
      end
      err_d = err_step[9:0];
    end

    done = x_major_d ? (walk_x_d == target_x_d) : (walk_y_d == target_y_d);

    if (rotate_i) begin
      pixel_o.pixel_x = walk_y_d;
      pixel_o.pixel_y = ScreenMaxLo - walk_x_d;
    end else begin
      pixel_o.pixel_x = walk_x_d;
      pixel_o.pixel_y = walk_y_d;
    end
    pixel_o.pixel_color = color_d;
    pixel_o.last        = done;
  end

  assign has_result_o = start || active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q   <= '0;
      walk_y_q   <= '0;
      target_x_q <= '0;
      target_y_q <= '0;
      twice_dx_q <= '0;
      twice_dy_q <= '0;
      neg_x_q    <= 1'b0;
      neg_y_q    <= 1'b0;
      err_q      <= '0;
      x_major_q  <= 1'b0;
      color_q    <= '0;
      active_q   <= 1'b0;
    end else if (fire_i && has_result_o) begin
      walk_x_q   <= walk_x_d;
      walk_y_q   <= walk_y_d;
      target_x_q <= target_x_d;
      target_y_q <= target_y_d;
      twice_dx_q <= twice_dx_d;
      twice_dy_q <= twice_dy_d;
      neg_x_q    <= neg_x_d;
      neg_y_q    <= neg_y_d;
      err_q      <= err_d;
      x_major_q  <= x_major_d;
      color_q    <= color_d;
      active_q   <= !done;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bresenham_line_pixel_generator_core.sv =====
`default_nettype none

// Integer line walker for a small pixel screen. A start word (mode 0) loads two
// endpoints and a 12-bit color and yields the first pixel; each step word
// (mode 1) yields the next pixel along the line, and the final pixel carries
// last. A step word with no line in progress is consumed and yields nothing.
// A start word always abandons any line in progress. With rotate set, the
// endpoints are swapped x<->y at start and every pixel leaves as
// (y, SCREEN_MAX - x), wrapped to 8 bits; rotate is read at the start word for
// the axis swap and again at each pixel for the mapping. Rate: one word per
// clock while the input stage does not stall; each word passes the input
// register, then the result register, and the error-term update of the walker
// sits between the two, so the walker state is ready for the next word every
// cycle. The input stage only stalls when a pixel is ready and the result
// register is full and stalled. rotate is written through the cfg channel,
// always ready; write it only while no word is in flight.

`include "bresenham_line_pixel_generator_core_assert.svh"

module bresenham_line_pixel_generator_core
  import blpg_pkg::*;
#(
  parameter int unsigned SCREEN_MAX = 131
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // item input
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire blpg_in_t  in_data_i,
  // pixel output
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output blpg_out_t      out_data_o,
  // rotate register write
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic      cfg_data_i
);

  logic      rotate_q;
  logic      in_valid_q;
  blpg_in_t  in_q;
  logic      out_valid_q;
  blpg_out_t out_q;

  logic      in_accept;
  logic      advance;
  logic      has_result;
  blpg_out_t pixel;

  // rotate register, written any time the channel is valid
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rotate_q <= cfg_data_i;
    end
  end

  // held word moves on when it makes no pixel or the result register has room
  assign advance    = in_valid_q && (!has_result || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // walker: state plus one error-term update per word
  blpg_walker #(
    .SCREEN_MAX(SCREEN_MAX)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (in_q),
    .rotate_i    (rotate_q),
    .has_result_o(has_result),
    .pixel_o     (pixel)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q <= pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `BLPG_ASSERT_NOW(a_stall_needs_word, in_stall_o, in_valid_q,
                   "input stalled with no held word")
  `BLPG_ASSERT_NEXT(a_pixel_lands, advance && has_result, out_valid_q,
                    "pixel lost on its way to the result register")
  `BLPG_ASSERT_NOW(a_no_overwrite, out_valid_q && out_stall_i && in_valid_q && has_result,
                   in_stall_o, "held pixel would be overwritten")

endmodule

`default_nettype wire
